// File: sv/assert_macros.svh
// Assertion macros shared by the codon translator RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("rct assertion failed");
`define RCT_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("rct forbidden condition");
`else
`define RCT_ASSERT(lbl, prop)
`define RCT_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: sv/rct_pkg.sv
// Package for the codon translator: widths, residue codes, genetic code table
// and the transaction type passed from front to back. No dependencies.
package rct_pkg;

	localparam int COUNT_BITS = 16;
	localparam int SHOW_W     = 16;
	localparam int CNT_EXT_W  = (COUNT_BITS > SHOW_W) ? COUNT_BITS : SHOW_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [2:0] BASE_A     = 3'd0;
	localparam logic [2:0] BASE_C     = 3'd1;
	localparam logic [2:0] BASE_G     = 3'd2;
	localparam logic [2:0] BASE_U     = 3'd3;
	localparam logic [2:0] BASE_OTHER = 3'd4;

	localparam logic [4:0] CODE_STOP    = 5'd20;
	localparam logic [4:0] CODE_UNKNOWN = 5'd21;
	localparam logic [4:0] CODE_PARTIAL = 5'd22;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	// index = first*16 + second*4 + third, A=0 C=1 G=2 U=3
	localparam logic [4:0] CODE_TABLE [64] = '{
		5'd11, 5'd2,  5'd11, 5'd2,  5'd16, 5'd16, 5'd16, 5'd16,
		5'd1,  5'd15, 5'd1,  5'd15, 5'd9,  5'd9,  5'd12, 5'd9,
		5'd6,  5'd8,  5'd6,  5'd8,  5'd14, 5'd14, 5'd14, 5'd14,
		5'd1,  5'd1,  5'd1,  5'd1,  5'd10, 5'd10, 5'd10, 5'd10,
		5'd5,  5'd3,  5'd5,  5'd3,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd7,  5'd7,  5'd7,  5'd7,  5'd19, 5'd19, 5'd19, 5'd19,
		5'd20, 5'd18, 5'd20, 5'd18, 5'd15, 5'd15, 5'd15, 5'd15,
		5'd20, 5'd4,  5'd17, 5'd4,  5'd10, 5'd13, 5'd10, 5'd13
	};

	typedef struct packed {
		logic       partial;
		logic       unknown;
		logic [5:0] idx;
		logic       last;
	} job_t;

	function automatic logic [2:0] base_code(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			8'h41:   r = BASE_A;
			8'h43:   r = BASE_C;
			8'h47:   r = BASE_G;
			8'h55:   r = BASE_U;
			default: r = BASE_OTHER;
		endcase
		return r;
	endfunction

endpackage

// File: sv/rct_front.sv
// Front end: takes bases, classifies them and assembles codon transactions.
// Depends on rct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rct_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       base_char,
	input  logic             sequence_end,
	output logic             full,
	input  logic             q_full,
	output logic             q_push,
	output rct_pkg::job_t    q_job
);

	logic [1:0] phase_q;
	logic [2:0] held_q [2];
	logic [2:0] b;
	logic       accept;
	logic       early;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign b      = rct_pkg::base_code(base_char);
	// phase 3 cannot arise; treated as third base
	assign early  = (phase_q == rct_pkg::PHASE_FIRST) || (phase_q == rct_pkg::PHASE_SECOND);

	assign q_push = accept && (!early || sequence_end);

	always_comb begin
		q_job.partial = early;
		q_job.unknown = held_q[0][2] | held_q[1][2] | b[2];
		q_job.idx     = {held_q[0][1:0], held_q[1][1:0], b[1:0]};
		q_job.last    = sequence_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rct_pkg::PHASE_FIRST;
			held_q[0] <= rct_pkg::BASE_A;
			held_q[1] <= rct_pkg::BASE_A;
		end else if (accept) begin
			if (early)
				held_q[phase_q[0]] <= b;
			if (q_push)
				phase_q <= rct_pkg::PHASE_FIRST;
			else
				phase_q <= phase_q + 2'd1;
		end
	end

	`RCT_ASSERT_NEVER(a_phase_range, phase_q == 2'd3)
	`RCT_ASSERT(a_codon_on_third, q_push && !q_job.partial |-> phase_q == rct_pkg::PHASE_THIRD)

endmodule

// File: sv/rct_fifo.sv
// Short transaction queue between the front and back ends.
// Depends on rct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rct_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rct_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output rct_pkg::job_t rdata,
	output logic          empty
);

	rct_pkg::job_t             slot_q [rct_pkg::FIFO_DEPTH];
	logic [rct_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [rct_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [rct_pkg::FIFO_AW:0]   cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (cnt_q == (rct_pkg::FIFO_AW+1)'(rct_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`RCT_ASSERT(a_cnt_bound, cnt_q <= (rct_pkg::FIFO_AW+1)'(rct_pkg::FIFO_DEPTH))
	`RCT_ASSERT_NEVER(a_push_when_full, push && full)

endmodule

// File: sv/rct_back.sv
// Back end: translates codon transactions, keeps the residue count and holds
// the result register. Depends on rct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rct_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  rct_pkg::job_t                  q_job,
	output logic                           q_pop,
	output logic                           empty,
	input  logic                           pop,
	output logic [4:0]                     residue_code,
	output logic [rct_pkg::SHOW_W-1:0]     residue_count,
	output logic                           last_result
);

	localparam logic [rct_pkg::COUNT_BITS-1:0] CntMax = '1;
	localparam logic [rct_pkg::CNT_EXT_W-1:0]  ShowMax =
		rct_pkg::CNT_EXT_W'({rct_pkg::SHOW_W{1'b1}});

	logic                            out_valid_q;
	logic [4:0]                      code_q;
	logic [rct_pkg::SHOW_W-1:0]      count_q;
	logic                            last_q;
	logic [rct_pkg::COUNT_BITS-1:0]  counter_q;
	logic [rct_pkg::COUNT_BITS-1:0]  inc;
	logic [rct_pkg::COUNT_BITS-1:0]  shown_src;
	logic [rct_pkg::CNT_EXT_W-1:0]   shown_ext;
	logic [rct_pkg::SHOW_W-1:0]      shown;
	logic [4:0]                      code;

	assign q_pop = !q_empty && (!out_valid_q || pop);

	assign inc       = (counter_q != CntMax) ? counter_q + 1'b1 : counter_q;
	// a dropped partial codon reports the count unchanged
	assign shown_src = q_job.partial ? counter_q : inc;
	assign shown_ext = rct_pkg::CNT_EXT_W'(shown_src);
	assign shown     = (shown_ext > ShowMax) ? {rct_pkg::SHOW_W{1'b1}}
		: shown_ext[rct_pkg::SHOW_W-1:0];

	always_comb begin
		if (q_job.partial)
			code = rct_pkg::CODE_PARTIAL;
		else if (q_job.unknown)
			code = rct_pkg::CODE_UNKNOWN;
		else
			code = rct_pkg::CODE_TABLE[q_job.idx];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_q  <= code;
			count_q <= shown;
			last_q  <= q_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			counter_q   <= '0;
		end else begin
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (q_pop) begin
				if (q_job.last)
					counter_q <= '0;
				else
					counter_q <= inc;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign residue_code  = code_q;
	assign residue_count = count_q;
	assign last_result   = last_q;

	`RCT_ASSERT(a_cnt_clear_on_last, q_pop && q_job.last |=> counter_q == '0)
	`RCT_ASSERT(a_partial_is_last, q_pop && q_job.partial |-> q_job.last)

endmodule

// File: sv/rct_top.sv
// Top level of the RNA codon translator: front end, transaction queue and back end.
// Depends on rct_pkg, rct_front, rct_fifo and rct_back.
//
// Input channel: push/full with base_char (ASCII) and sequence_end. A base is
// taken at each edge with push high and full low, one per cycle sustained.
// Output channel: empty/pop with residue_code, residue_count and last_result.
// A result is produced on every third base of a codon, and on a base that
// carries sequence_end before the codon is complete (partial marker, code 22).
// A result shows (empty low) once it has gone through the queue, which the edge
// that takes its base writes, and the result register, which loads when empty or popped.
// Bases are taken one per cycle while full stays low; the table lookup in the back
// end is combinational, and the four-entry queue absorbs bursts of output stall.
// When the receiver holds pop low, the result register stays, the queue
// fills and full rises once all four entries hold transactions.
// Reset (arst_n low) clears codon phase, held bases, residue count, queue state
// and result valid flag (not the result data); no result is pending after reset.
module rna_codon_translator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 base_char,
	input  logic                       sequence_end,
	output logic                       empty,
	input  logic                       pop,
	output logic [4:0]                 residue_code,
	output logic [rct_pkg::SHOW_W-1:0] residue_count,
	output logic                       last_result
);

	logic          q_full;
	logic          q_push;
	logic          q_empty;
	logic          q_pop;
	rct_pkg::job_t wjob;
	rct_pkg::job_t rjob;

	rct_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.base_char    (base_char),
		.sequence_end (sequence_end),
		.full         (full),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (wjob)
	);

	rct_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (wjob),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (rjob),
		.empty  (q_empty)
	);

	rct_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (rjob),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.residue_code  (residue_code),
		.residue_count (residue_count),
		.last_result   (last_result)
	);

endmodule
